FILE: src/btff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btff_pkg: shared types and codes of the boundary-tag allocator
// Command and status codes, transaction payload structs and the sequencer
// state type used by the allocator top level.
// ----------------------------------------------------------------------------
package btff_pkg;

	localparam int CFG_W      = 17;
	localparam int CMD_W      = 2;
	localparam int SIZE_W     = 16;
	localparam int ADDR_W     = 16;
	localparam int STATUS_W   = 2;
	localparam int ARENA_SIZE_RST = 65536;

	localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FREE   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_FORMAT = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

	localparam logic [STATUS_W-1:0] STS_DONE         = 2'd0;
	localparam logic [STATUS_W-1:0] STS_NO_FIT       = 2'd1;
	localparam logic [STATUS_W-1:0] STS_ALREADY_FREE = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  command;
		logic [SIZE_W-1:0] request_size;
		logic [ADDR_W-1:0] address;
	} btff_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [ADDR_W-1:0]   address_res;
	} btff_rsp_t;

	typedef enum logic [4:0] {
		S_CLEAR,
		S_FMT_H,
		S_FMT_F,
		S_IDLE,
		S_DONE,
		S_A_RD,
		S_A_EVAL,
		S_A_SPLIT_H,
		S_A_SPLIT_F,
		S_A_USE_H,
		S_A_USE_F,
		S_A_NEXT,
		S_F_CHK,
		S_F_T,
		S_F_P_RD,
		S_F_P,
		S_F_P2,
		S_F_N_RD,
		S_F_N,
		S_F_WH,
		S_F_WF
	} btff_state_t;

endpackage

FILE: src/btff_tag_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btff_tag_ram: tag store of the boundary-tag allocator
// One tag per arena byte offset, one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module btff_tag_ram #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int TW    = 17
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [TW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [TW-1:0] rdata
);

	logic [TW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: src/boundary_tag_first_fit_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// boundary_tag_first_fit_allocator: first-fit allocator with boundary tags
// Commands arrive on cmd (valid/ready) and each produces one transaction on
// rsp (valid/ready) unless cfg_we aborts it. cfg_we writes the arena size
// and formats the arena.
// Usage and sequencing:
// - One command is handled at a time; cmd_ready is high only while idle.
// - Allocate walks the blocks from offset 0 through the tag memory, reading,
//   evaluating and stepping past each block passed over. The block taken has
//   its header and footer marked used, after the free front part's tags when
//   it is split, and then the response is posted; no fit posts STS_NO_FIT.
// - Free does up to three tag reads and two tag writes.
// - Format responds after the tag sweep and the format writes; no-operation
//   responds without touching the tag memory.
// - Reset and every configuration write start a clearing sweep of the tag
//   memory, one entry per cycle; no command is taken meanwhile.
// - A finished response is held in an output register; a new command can be
//   taken while it waits. If the receiver stalls with one response already
//   held, the next response waits in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module boundary_tag_first_fit_allocator #(
	parameter int ARENA_BYTES  = 65536,
	parameter int HEADER_BYTES = 13
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [btff_pkg::CFG_W-1:0] cfg_wdata,
	input  logic                     cmd_valid,
	output logic                     cmd_ready,
	input  btff_pkg::btff_cmd_t      cmd,
	output logic                     rsp_valid,
	input  logic                     rsp_ready,
	output btff_pkg::btff_rsp_t      rsp
);

	import btff_pkg::*;

	localparam int AW = $clog2(ARENA_BYTES);
	localparam int TW = AW + 1;
	localparam int DW = (AW + 2 > 19) ? AW + 2 : 19;
	localparam logic [DW-1:0] HB_D    = DW'(HEADER_BYTES);
	localparam logic [DW-1:0] HB2_D   = DW'(2 * HEADER_BYTES);
	localparam logic [DW-1:0] ARENA_D = DW'(ARENA_BYTES);
	localparam logic [AW-1:0] CLR_LAST = AW'(ARENA_BYTES - 1);
	localparam logic [DW-1:0] END_RST =
		(ARENA_SIZE_RST > ARENA_BYTES) ? DW'(ARENA_BYTES) :
		((ARENA_SIZE_RST < 2 * HEADER_BYTES) ? DW'(2 * HEADER_BYTES) :
		DW'(ARENA_SIZE_RST));

	btff_state_t state_q, state_d;

	logic [DW-1:0] end_q;
	logic [AW-1:0] clr_q;
	logic          fmt_pend_q;
	logic          rsp_valid_q;
	btff_rsp_t     rsp_q;

	logic [DW-1:0] cur_q, tmp_q, start_q, span_q, sz_q, pspan_q;
	logic [DW-1:0] req_q, req26_q, req3_q;
	logic          pused_q;
	logic [STATUS_W-1:0] status_q;
	logic [ADDR_W-1:0]   res_q;

	logic [DW-1:0] cfg_val, cfg_end;
	logic [DW-1:0] nxt;
	logic [DW-1:0] rd_addr, wr_pos, wr_size;
	logic          wr_req, wr_used, clr_we;
	logic          rd_used;
	logic [DW-1:0] rd_size;
	logic          fit, split;
	logic          rsp_load;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [TW-1:0] ram_wdata, ram_rdata;

	btff_tag_ram #(
		.DEPTH(ARENA_BYTES),
		.AW(AW),
		.TW(TW)
	) u_tag_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr[AW-1:0]),
		.rdata(ram_rdata)
	);

	assign rd_used = ram_rdata[AW];
	assign rd_size = DW'(ram_rdata[AW-1:0]);
	assign nxt     = cur_q + sz_q + HB2_D;
	assign split   = !rd_used && ((rd_size << 1) > req3_q) && (rd_size >= req26_q);
	assign fit     = !rd_used && (rd_size >= req_q);

	assign cfg_val = DW'(cfg_wdata);
	assign cfg_end = (cfg_val > ARENA_D) ? ARENA_D :
		((cfg_val < HB2_D) ? HB2_D : cfg_val);

	assign ram_we    = clr_we || (wr_req && (wr_pos < end_q));
	assign ram_waddr = clr_we ? clr_q : wr_pos[AW-1:0];
	assign ram_wdata = clr_we ? '0 : {wr_used, wr_size[AW-1:0]};

	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else if (cfg_we) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		rd_addr = cur_q;
		wr_req  = 1'b0;
		wr_pos  = cur_q;
		wr_used = 1'b0;
		wr_size = sz_q;
		clr_we  = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				clr_we = 1'b1;
				if (clr_q == CLR_LAST) begin
					state_d = S_FMT_H;
				end
			end
			S_FMT_H: begin
				wr_req  = 1'b1;
				wr_pos  = '0;
				wr_size = end_q - HB2_D;
				state_d = S_FMT_F;
			end
			S_FMT_F: begin
				wr_req  = 1'b1;
				wr_pos  = end_q - HB_D;
				wr_size = end_q - HB2_D;
				state_d = fmt_pend_q ? S_DONE : S_IDLE;
			end
			S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.command)
						CMD_ALLOC:  state_d = S_A_RD;
						CMD_FREE:   state_d = S_F_CHK;
						CMD_FORMAT: state_d = S_CLEAR;
						default:    state_d = S_DONE;
					endcase
				end
			end
			S_DONE: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			S_A_RD: begin
				state_d = S_A_EVAL;
			end
			S_A_EVAL: begin
				if (split) begin
					state_d = S_A_SPLIT_H;
				end else if (fit) begin
					state_d = S_A_USE_H;
				end else begin
					state_d = S_A_NEXT;
				end
			end
			S_A_SPLIT_H: begin
				wr_req  = 1'b1;
				wr_size = span_q;
				state_d = S_A_SPLIT_F;
			end
			S_A_SPLIT_F: begin
				wr_req  = 1'b1;
				wr_pos  = tmp_q - HB_D;
				wr_size = span_q;
				state_d = S_A_USE_H;
			end
			S_A_USE_H: begin
				wr_req  = 1'b1;
				wr_used = 1'b1;
				state_d = S_A_USE_F;
			end
			S_A_USE_F: begin
				wr_req  = 1'b1;
				wr_pos  = tmp_q;
				wr_used = 1'b1;
				state_d = S_DONE;
			end
			S_A_NEXT: begin
				state_d = (nxt >= end_q) ? S_DONE : S_A_RD;
			end
			S_F_CHK: begin
				state_d = (cur_q >= end_q) ? S_DONE : S_F_T;
			end
			S_F_T: begin
				state_d = rd_used ? S_F_P_RD : S_DONE;
			end
			S_F_P_RD: begin
				rd_addr = cur_q - HB_D;
				state_d = (cur_q >= HB_D) ? S_F_P : S_F_N_RD;
			end
			S_F_P: begin
				state_d = S_F_P2;
			end
			S_F_P2: begin
				state_d = S_F_N_RD;
			end
			S_F_N_RD: begin
				rd_addr = nxt;
				state_d = (nxt < end_q) ? S_F_N : S_F_WH;
			end
			S_F_N: begin
				state_d = S_F_WH;
			end
			S_F_WH: begin
				wr_req  = 1'b1;
				wr_pos  = start_q;
				wr_size = span_q - HB2_D;
				state_d = S_F_WF;
			end
			S_F_WF: begin
				wr_req  = 1'b1;
				wr_pos  = tmp_q;
				wr_size = span_q - HB2_D;
				state_d = S_DONE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_q       <= END_RST;
			clr_q       <= '0;
			fmt_pend_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				end_q <= cfg_end;
			end
			if (cfg_we || state_q != S_CLEAR) begin
				clr_q <= '0;
			end else begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				fmt_pend_q <= 1'b0;
			end else if (state_q == S_IDLE && cmd_valid) begin
				fmt_pend_q <= (cmd.command == CMD_FORMAT);
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q.status      <= status_q;
			rsp_q.address_res <= res_q;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					cur_q    <= (cmd.command == CMD_FREE) ?
						DW'(cmd.address) - HB_D : '0;
					req_q    <= DW'(cmd.request_size);
					req26_q  <= DW'(cmd.request_size) + HB2_D;
					req3_q   <= (DW'(cmd.request_size) << 1) + DW'(cmd.request_size);
					status_q <= STS_DONE;
					res_q    <= '0;
				end
			end
			S_A_EVAL: begin
				sz_q   <= rd_size;
				span_q <= rd_size - req26_q;
			end
			S_A_SPLIT_H: begin
				tmp_q <= cur_q + sz_q - req_q;
			end
			S_A_SPLIT_F: begin
				cur_q <= tmp_q;
				sz_q  <= req_q;
			end
			S_A_USE_H: begin
				tmp_q <= cur_q + sz_q + HB_D;
			end
			S_A_USE_F: begin
				res_q <= ADDR_W'(cur_q + HB_D);
			end
			S_A_NEXT: begin
				if (nxt >= end_q) begin
					status_q <= STS_NO_FIT;
				end else begin
					cur_q <= nxt;
				end
			end
			S_F_CHK: begin
				if (cur_q >= end_q) begin
					status_q <= STS_ALREADY_FREE;
				end
			end
			S_F_T: begin
				if (!rd_used) begin
					status_q <= STS_ALREADY_FREE;
				end
				sz_q    <= rd_size;
				start_q <= cur_q;
				span_q  <= rd_size + HB2_D;
			end
			S_F_P: begin
				pused_q <= rd_used;
				pspan_q <= rd_size + HB2_D;
			end
			S_F_P2: begin
				if (!pused_q && pspan_q <= cur_q) begin
					start_q <= cur_q - pspan_q;
					span_q  <= span_q + pspan_q;
				end
			end
			S_F_N: begin
				if (!rd_used) begin
					span_q <= span_q + rd_size + HB2_D;
				end
			end
			S_F_WH: begin
				tmp_q <= start_q + span_q - HB_D;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the boundary-tag first-fit allocator
// A queue-fed driver issues allocate, free, format and no-op commands while a
// predictor keeps its own copy of the tag memory. It computes the expected
// response of every accepted command. A monitor compares each response
// transaction with the oldest prediction. The run goes through several arena
// sizes with random idle gaps on both channels.
// ----------------------------------------------------------------------------
module tb_top;
	import btff_pkg::*;

	localparam int ARENA_MAX = 65536;
	localparam int HDR       = 13;
	localparam int TAGS2     = 2 * HDR;

	typedef struct {
		bit          used;
		int unsigned size;
	} block_tag_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CFG_W-1:0]    cfg_wdata = '0;
	logic                cmd_valid = 1'b0;
	logic                cmd_ready;
	btff_cmd_t           cmd       = '0;
	logic                rsp_valid;
	logic                rsp_ready = 1'b0;
	btff_rsp_t           rsp;

	block_tag_t          tag_mem [ARENA_MAX];
	int unsigned         arena_cfg = ARENA_SIZE_RST;
	btff_cmd_t           queued_commands[$];
	btff_rsp_t           awaited_responses[$];
	logic [ADDR_W-1:0]   live_blocks[$];
	logic [ADDR_W-1:0]   last_freed = '0;
	bit                  idle_gaps = 1'b1;
	int                  cmd_gap = 0;
	int                  rsp_hold = 0;
	int                  mismatch_count = 0;
	btff_rsp_t           predicted;
	btff_rsp_t           wanted_rsp;

	boundary_tag_first_fit_allocator #(
		.ARENA_BYTES (ARENA_MAX),
		.HEADER_BYTES(HDR)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int unsigned arena_limit();
		int unsigned a;
		a = arena_cfg;
		if (a > ARENA_MAX) a = ARENA_MAX;
		if (a < TAGS2) a = TAGS2;
		return a;
	endfunction

	function automatic block_tag_t fetch_tag(int unsigned pos);
		block_tag_t t;
		t.used = 1'b0;
		t.size = 0;
		if (pos < arena_limit()) t = tag_mem[pos];
		return t;
	endfunction

	function automatic void store_tag(int unsigned pos, bit used, int unsigned size);
		if (pos < arena_limit()) begin
			tag_mem[pos].used = used;
			tag_mem[pos].size = size;
		end
	endfunction

	function automatic void lay_block(int unsigned start, int unsigned span, bit used);
		store_tag(start, used, span - TAGS2);
		store_tag(start + span - HDR, used, span - TAGS2);
	endfunction

	function automatic void wipe_arena();
		for (int i = 0; i < ARENA_MAX; i++) begin
			tag_mem[i].used = 1'b0;
			tag_mem[i].size = 0;
		end
		lay_block(0, arena_limit(), 1'b0);
	endfunction

	function automatic bit first_fit(int unsigned req, output logic [ADDR_W-1:0] payload_at);
		int unsigned lim, cur, b, front;
		block_tag_t t;
		lim = arena_limit();
		cur = 0;
		payload_at = '0;
		while (cur < lim) begin
			t = fetch_tag(cur);
			b = t.size;
			if (!t.used) begin
				if (2 * longint'(b) > 3 * longint'(req) &&
				    longint'(b) >= longint'(req) + TAGS2) begin
					front = b - req;
					lay_block(cur, front, 1'b0);
					cur += front;
					lay_block(cur, req + TAGS2, 1'b0);
					b = req;
				end
				if (b >= req) begin
					lay_block(cur, b + TAGS2, 1'b1);
					payload_at = ADDR_W'(cur + HDR);
					return 1'b1;
				end
			end
			if (longint'(cur) + longint'(b) + TAGS2 >= longint'(lim)) break;
			cur += b + TAGS2;
		end
		return 1'b0;
	endfunction

	function automatic logic [STATUS_W-1:0] release_block(int unsigned addr);
		int unsigned lim, cur, start, span;
		block_tag_t t, p, n;
		lim = arena_limit();
		if (addr < HDR) return STS_ALREADY_FREE;
		cur = addr - HDR;
		t = fetch_tag(cur);
		if (!t.used) return STS_ALREADY_FREE;
		start = cur;
		span = t.size + TAGS2;
		if (cur >= HDR) begin
			p = fetch_tag(cur - HDR);
			if (!p.used && longint'(p.size) + TAGS2 <= longint'(cur)) begin
				start = cur - p.size - TAGS2;
				span += p.size + TAGS2;
			end
		end
		if (longint'(cur) + longint'(t.size) + TAGS2 < longint'(lim)) begin
			n = fetch_tag(cur + t.size + TAGS2);
			if (!n.used) span += n.size + TAGS2;
		end
		lay_block(start, span, 1'b0);
		return STS_DONE;
	endfunction

	function automatic btff_rsp_t allocator_response(btff_cmd_t c);
		btff_rsp_t r;
		logic [ADDR_W-1:0] at;
		r.status = STS_DONE;
		r.address_res = '0;
		case (c.command)
			CMD_ALLOC: begin
				if (first_fit(c.request_size, at)) begin
					r.address_res = at;
				end else begin
					r.status = STS_NO_FIT;
				end
			end
			CMD_FREE: r.status = release_block(c.address);
			CMD_FORMAT: wipe_arena();
			default: ;
		endcase
		return r;
	endfunction

	function automatic bit free_is_inert(logic [ADDR_W-1:0] a);
		block_tag_t t;
		if (a < HDR) return 1'b1;
		t = fetch_tag(a - HDR);
		return !t.used;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			cmd_gap = 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				predicted = allocator_response(cmd);
				awaited_responses.insert(awaited_responses.size(), predicted);
				if (cmd.command == CMD_ALLOC && predicted.status == STS_DONE)
					live_blocks.insert(live_blocks.size(), predicted.address_res);
				if (cmd.command == CMD_FORMAT) live_blocks.delete();
				cmd_gap = idle_gaps ? $urandom_range(0, 4) : 0;
			end
			if (!cmd_valid || cmd_ready) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
					cmd_valid <= 1'b0;
				end else if (queued_commands.size() != 0) begin
					cmd <= queued_commands.pop_front();
					cmd_valid <= 1'b1;
				end else begin
					cmd_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_hold = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_responses.size() == 0) begin
					$error("response transaction with nothing outstanding: status %0d address_res %0d",
						rsp.status, rsp.address_res);
					mismatch_count++;
				end else begin
					wanted_rsp = awaited_responses.pop_front();
					if (rsp.status !== wanted_rsp.status) begin
						$error("status: expected %0d, actual %0d", wanted_rsp.status, rsp.status);
						mismatch_count++;
					end
					if (rsp.address_res !== wanted_rsp.address_res) begin
						$error("address_res: expected %0d, actual %0d",
							wanted_rsp.address_res, rsp.address_res);
						mismatch_count++;
					end
				end
				rsp_hold = idle_gaps ? $urandom_range(0, 4) : 0;
			end else if (rsp_hold > 0) begin
				rsp_hold--;
			end
			rsp_ready <= (rsp_hold == 0);
		end
	end

	task automatic await_free_slot();
		while (queued_commands.size() != 0 || cmd_valid) @(negedge clk);
	endtask

	task automatic post_command(logic [CMD_W-1:0] op, logic [SIZE_W-1:0] size,
		logic [ADDR_W-1:0] addr);
		btff_cmd_t c;
		await_free_slot();
		c.command = op;
		c.request_size = size;
		c.address = addr;
		queued_commands.insert(queued_commands.size(), c);
	endtask

	task automatic free_live(int which);
		int idx;
		logic [ADDR_W-1:0] a;
		await_free_slot();
		idx = (which < 0) ? live_blocks.size() - 1 : which;
		a = live_blocks[idx];
		live_blocks.delete(idx);
		last_freed = a;
		post_command(CMD_FREE, SIZE_W'($urandom), a);
	endtask

	task automatic drain();
		await_free_slot();
		while (awaited_responses.size() != 0) @(negedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic reconfigure(int unsigned bytes);
		drain();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(bytes);
		arena_cfg = bytes & 32'h1FFFF;
		wipe_arena();
		live_blocks.delete();
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_items(int count, int format_permille);
		int pick, slot, tries;
		int unsigned lim;
		logic [CMD_W-1:0] op;
		logic [SIZE_W-1:0] size;
		logic [ADDR_W-1:0] addr;
		for (int i = 0; i < count; i++) begin
			await_free_slot();
			if (i % 50 == 0) idle_gaps = ($urandom_range(0, 3) != 0);
			lim = arena_limit();
			op = CMD_NOP;
			size = SIZE_W'($urandom);
			addr = ADDR_W'($urandom);
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 999) < format_permille) begin
				op = CMD_FORMAT;
			end else if (pick < 45 || (pick < 85 && live_blocks.size() == 0)) begin
				op = CMD_ALLOC;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: size = SIZE_W'($urandom_range(0, lim / 16));
					6, 7: size = SIZE_W'($urandom_range(0, lim - TAGS2));
					default: ;
				endcase
			end else if (pick < 85) begin
				op = CMD_FREE;
				slot = $urandom_range(0, live_blocks.size() - 1);
				addr = live_blocks[slot];
				live_blocks.delete(slot);
				last_freed = addr;
			end else if (pick < 94) begin
				// Stray frees only ever land on tags that read as free.
				op = CMD_FREE;
				if (pick < 88) addr = last_freed;
				for (tries = 0; tries < 8 && !free_is_inert(addr); tries++)
					addr = ADDR_W'($urandom);
				if (!free_is_inert(addr)) addr = ADDR_W'($urandom_range(0, HDR - 1));
			end
			post_command(op, size, addr);
		end
	endtask

	initial begin
		block_tag_t front;
		wipe_arena();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		post_command(CMD_NOP, '1, '1);
		post_command(CMD_ALLOC, '0, ADDR_W'($urandom));
		post_command(CMD_ALLOC, '1, '0);
		await_free_slot();
		front = fetch_tag(0);
		post_command(CMD_ALLOC, SIZE_W'(front.size), '1);
		post_command(CMD_ALLOC, '0, '0);
		post_command(CMD_FREE, '1, '0);
		post_command(CMD_FREE, '0, ADDR_W'(HDR - 1));
		free_live(-1);
		post_command(CMD_FREE, '0, last_freed);
		post_command(CMD_ALLOC, SIZE_W'(100), '0);
		post_command(CMD_ALLOC, SIZE_W'(40), '0);
		free_live(0);
		free_live(0);
		free_live(0);
		post_command(CMD_ALLOC, SIZE_W'(ARENA_MAX - TAGS2), '0);
		free_live(0);
		post_command(CMD_FORMAT, '1, '1);
		post_command(CMD_ALLOC, SIZE_W'(20), '1);
		random_items(150, 0);

		reconfigure(TAGS2);
		post_command(CMD_ALLOC, '0, '0);
		post_command(CMD_ALLOC, '0, '0);
		free_live(0);
		post_command(CMD_FREE, '0, last_freed);
		random_items(20, 0);

		reconfigure(60);
		post_command(CMD_ALLOC, SIZE_W'(20), '0);
		free_live(0);
		post_command(CMD_ALLOC, SIZE_W'(8), '0);
		post_command(CMD_ALLOC, '0, '0);
		post_command(CMD_ALLOC, '0, '0);
		free_live(0);
		free_live(0);
		random_items(40, 0);

		reconfigure(2000);
		random_items(800, 3);

		reconfigure(ARENA_MAX);
		random_items(220, 0);

		drain();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && awaited_responses.size() == 0) begin
			$display("tb_top: clean");
		end else begin
			$display("tb_top: errors");
		end
		$finish;
	end

	initial begin
		#40_000_000;
		$display("tb_top: errors");
		$finish;
	end

endmodule
